>>> src/vpcd_pkg.sv
// ----------------------------------------------------------------------------
// vpcd_pkg
// Shared types and codes for the vector picture command decoder.
// ----------------------------------------------------------------------------
package vpcd_pkg;

   // command nibbles (low nibble of an F0-FA byte)
   localparam logic [3:0] CMD_VIS_SET   = 4'h0;
   localparam logic [3:0] CMD_VIS_OFF   = 4'h1;
   localparam logic [3:0] CMD_PRI_SET   = 4'h2;
   localparam logic [3:0] CMD_PRI_OFF   = 4'h3;
   localparam logic [3:0] CMD_CORNER_Y  = 4'h4;
   localparam logic [3:0] CMD_CORNER_X  = 4'h5;
   localparam logic [3:0] CMD_ABS_LINE  = 4'h6;
   localparam logic [3:0] CMD_REL_LINE  = 4'h7;
   localparam logic [3:0] CMD_FILL      = 4'h8;
   localparam logic [3:0] CMD_BRUSH_SET = 4'h9;
   localparam logic [3:0] CMD_PLOT      = 4'hA;
   localparam logic [3:0] CMD_IDLE      = 4'hF;

   // argument phases
   localparam logic [1:0] PH_FIRST  = 2'd0;
   localparam logic [1:0] PH_SECOND = 2'd1;
   localparam logic [1:0] PH_THIRD  = 2'd2;
   localparam logic [1:0] PH_FOURTH = 2'd3;

   // result kinds
   localparam logic [2:0] KIND_PIXEL = 3'd0;
   localparam logic [2:0] KIND_LINE  = 3'd1;
   localparam logic [2:0] KIND_FILL  = 3'd2;
   localparam logic [2:0] KIND_BRUSH = 3'd3;
   localparam logic [2:0] KIND_END   = 3'd4;

   localparam logic [7:0] BYTE_CMD_MIN  = 8'hF0;
   localparam logic [7:0] BYTE_CMD_LAST = 8'hFA;
   localparam int         SPLATTER_BIT  = 5;

   localparam int TDATA_W = 72;
   localparam int TUSER_W = 3;

   typedef struct packed {
      logic [2:0] cmd_kind;
      logic [7:0] from_x;
      logic [7:0] from_y;
      logic [7:0] to_x;
      logic [7:0] to_y;
      logic       visual_on;
      logic [7:0] visual_colour;
      logic       priority_on;
      logic [7:0] priority_colour;
      logic [7:0] brush_code;
      logic [6:0] brush_number;
   } result_type;

endpackage

>>> src/vpcd_core.sv
// ----------------------------------------------------------------------------
// vpcd_core
// Command state and per-byte decode; gives at most one result per byte.
// ----------------------------------------------------------------------------
module vpcd_core #(
   parameter int PIC_WIDTH  = 160,
   parameter int PIC_HEIGHT = 168
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 byte_take,
   input  logic [7:0]           pic_byte,
   output logic                 res_valid,
   output vpcd_pkg::result_type res
);

   localparam logic [7:0] WIDTH8  = PIC_WIDTH[7:0];
   localparam logic [7:0] HEIGHT8 = PIC_HEIGHT[7:0];

   logic [3:0] cmd_ff, cmd_in;
   logic [1:0] phase_ff, phase_in;
   logic [7:0] pen_x_ff, pen_x_in, pen_y_ff, pen_y_in, pend_x_ff, pend_x_in;
   logic [7:0] vis_col_ff, vis_col_in, pri_col_ff, pri_col_in;
   logic       vis_en_ff, vis_en_in, pri_en_ff, pri_en_in;
   logic [7:0] brush_code_ff, brush_code_in;
   logic [6:0] brush_num_ff, brush_num_in;
   logic       finished_ff, finished_in;

   logic [2:0] size;
   logic [7:0] xlo, xhi, plot_x, plot_y, rel_x, rel_y;

   // brush centre clamp
   always_comb begin
      size = brush_code_ff[2:0];
      xlo  = {5'd0, 1'b0, size[2:1]} + 8'd1;
      xhi  = WIDTH8 - xlo;
      priority if (pend_x_ff < xlo) begin
         plot_x = xlo;
      end else if (pend_x_ff > xhi) begin
         plot_x = xhi;
      end else begin
         plot_x = pend_x_ff;
      end
      priority if (pic_byte < {5'd0, size}) begin
         plot_y = {5'd0, size};
      end else if (pic_byte >= HEIGHT8 - {5'd0, size}) begin
         plot_y = HEIGHT8 - 8'd1 - {5'd0, size};
      end else begin
         plot_y = pic_byte;
      end
   end

   // sign-magnitude displacement, wraps at 8 bits
   always_comb begin
      rel_x = pic_byte[7] ? pen_x_ff - {5'd0, pic_byte[6:4]}
                          : pen_x_ff + {5'd0, pic_byte[6:4]};
      rel_y = pic_byte[3] ? pen_y_ff - {5'd0, pic_byte[2:0]}
                          : pen_y_ff + {5'd0, pic_byte[2:0]};
   end

   always_comb begin
      logic       emit;
      logic [2:0] kind;
      logic [7:0] fx, fy, tx, ty;
      emit          = 1'b0;
      kind          = vpcd_pkg::KIND_PIXEL;
      fx            = 8'd0;
      fy            = 8'd0;
      tx            = 8'd0;
      ty            = 8'd0;
      cmd_in        = cmd_ff;
      phase_in      = phase_ff;
      pen_x_in      = pen_x_ff;
      pen_y_in      = pen_y_ff;
      pend_x_in     = pend_x_ff;
      vis_col_in    = vis_col_ff;
      vis_en_in     = vis_en_ff;
      pri_col_in    = pri_col_ff;
      pri_en_in     = pri_en_ff;
      brush_code_in = brush_code_ff;
      brush_num_in  = brush_num_ff;
      finished_in   = finished_ff;

      priority if (finished_ff) begin
         // hold: everything after the end is dropped
      end else if (cmd_ff == vpcd_pkg::CMD_VIS_SET || cmd_ff == vpcd_pkg::CMD_PRI_SET
                   || cmd_ff == vpcd_pkg::CMD_BRUSH_SET) begin
         // whole-byte argument, even a command code
         if (cmd_ff == vpcd_pkg::CMD_VIS_SET) begin
            vis_col_in = pic_byte;
            vis_en_in  = 1'b1;
         end else if (cmd_ff == vpcd_pkg::CMD_PRI_SET) begin
            pri_col_in = pic_byte;
            pri_en_in  = 1'b1;
         end else begin
            brush_code_in = pic_byte;
         end
         cmd_in   = vpcd_pkg::CMD_IDLE;
         phase_in = vpcd_pkg::PH_FIRST;
      end else if (pic_byte >= vpcd_pkg::BYTE_CMD_MIN) begin
         phase_in = vpcd_pkg::PH_FIRST;
         if (pic_byte > vpcd_pkg::BYTE_CMD_LAST) begin
            cmd_in      = vpcd_pkg::CMD_IDLE;
            finished_in = 1'b1;
            emit        = 1'b1;
            kind        = vpcd_pkg::KIND_END;
         end else if (pic_byte[3:0] == vpcd_pkg::CMD_VIS_OFF) begin
            vis_en_in = 1'b0;
            cmd_in    = vpcd_pkg::CMD_IDLE;
         end else if (pic_byte[3:0] == vpcd_pkg::CMD_PRI_OFF) begin
            pri_en_in = 1'b0;
            cmd_in    = vpcd_pkg::CMD_IDLE;
         end else begin
            cmd_in = pic_byte[3:0];
         end
      end else begin
         unique case (cmd_ff)
            vpcd_pkg::CMD_CORNER_Y, vpcd_pkg::CMD_CORNER_X,
            vpcd_pkg::CMD_ABS_LINE, vpcd_pkg::CMD_REL_LINE: begin
               if (phase_ff == vpcd_pkg::PH_FIRST) begin
                  pend_x_in = pic_byte;
                  phase_in  = vpcd_pkg::PH_SECOND;
               end else if (phase_ff == vpcd_pkg::PH_SECOND) begin
                  pen_x_in = pend_x_ff;
                  pen_y_in = pic_byte;
                  phase_in = vpcd_pkg::PH_THIRD;
                  emit     = 1'b1;
                  kind     = vpcd_pkg::KIND_PIXEL;
                  tx       = pend_x_ff;
                  ty       = pic_byte;
               end else if (cmd_ff == vpcd_pkg::CMD_REL_LINE) begin
                  emit = 1'b1;
                  tx   = rel_x;
                  ty   = rel_y;
               end else if (cmd_ff == vpcd_pkg::CMD_ABS_LINE) begin
                  if (phase_ff == vpcd_pkg::PH_THIRD) begin
                     pend_x_in = pic_byte;
                     phase_in  = vpcd_pkg::PH_FOURTH;
                  end else begin
                     phase_in = vpcd_pkg::PH_THIRD;
                     emit     = 1'b1;
                     tx       = pend_x_ff;
                     ty       = pic_byte;
                  end
               end else begin
                  // corner: axes alternate, F4 opens on y and F5 on x
                  emit     = 1'b1;
                  phase_in = (phase_ff == vpcd_pkg::PH_THIRD) ? vpcd_pkg::PH_FOURTH
                                                              : vpcd_pkg::PH_THIRD;
                  if ((phase_ff == vpcd_pkg::PH_THIRD) == (cmd_ff == vpcd_pkg::CMD_CORNER_Y))
                  begin
                     tx = pen_x_ff;
                     ty = pic_byte;
                  end else begin
                     tx = pic_byte;
                     ty = pen_y_ff;
                  end
               end
               if (emit && phase_ff != vpcd_pkg::PH_SECOND) begin
                  kind     = vpcd_pkg::KIND_LINE;
                  fx       = pen_x_ff;
                  fy       = pen_y_ff;
                  pen_x_in = tx;
                  pen_y_in = ty;
               end
            end
            vpcd_pkg::CMD_FILL: begin
               if (phase_ff == vpcd_pkg::PH_FIRST) begin
                  pend_x_in = pic_byte;
                  phase_in  = vpcd_pkg::PH_SECOND;
               end else begin
                  phase_in = vpcd_pkg::PH_FIRST;
                  emit     = 1'b1;
                  kind     = vpcd_pkg::KIND_FILL;
                  tx       = pend_x_ff;
                  ty       = pic_byte;
               end
            end
            vpcd_pkg::CMD_PLOT: begin
               if (phase_ff == vpcd_pkg::PH_FIRST) begin
                  if (brush_code_ff[vpcd_pkg::SPLATTER_BIT]) begin
                     brush_num_in = pic_byte[7:1];
                     phase_in     = vpcd_pkg::PH_SECOND;
                  end else begin
                     pend_x_in = pic_byte;
                     phase_in  = vpcd_pkg::PH_THIRD;
                  end
               end else if (phase_ff == vpcd_pkg::PH_SECOND) begin
                  pend_x_in = pic_byte;
                  phase_in  = vpcd_pkg::PH_THIRD;
               end else begin
                  phase_in = vpcd_pkg::PH_FIRST;
                  emit     = 1'b1;
                  kind     = vpcd_pkg::KIND_BRUSH;
                  tx       = plot_x;
                  ty       = plot_y;
               end
            end
            default: begin
               // stray low byte: drop
            end
         endcase
      end

      res_valid           = byte_take & emit;
      res.cmd_kind        = kind;
      res.from_x          = fx;
      res.from_y          = fy;
      res.to_x            = tx;
      res.to_y            = ty;
      res.visual_on       = vis_en_ff;
      res.visual_colour   = vis_col_ff;
      res.priority_on     = pri_en_ff;
      res.priority_colour = pri_col_ff;
      res.brush_code      = brush_code_ff;
      res.brush_number    = brush_num_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cmd_ff        <= vpcd_pkg::CMD_IDLE;
         phase_ff      <= vpcd_pkg::PH_FIRST;
         pen_x_ff      <= 8'd0;
         pen_y_ff      <= 8'd0;
         pend_x_ff     <= 8'd0;
         vis_col_ff    <= 8'd0;
         vis_en_ff     <= 1'b0;
         pri_col_ff    <= 8'd0;
         pri_en_ff     <= 1'b0;
         brush_code_ff <= 8'd0;
         brush_num_ff  <= 7'd0;
         finished_ff   <= 1'b0;
      end else if (byte_take) begin
         cmd_ff        <= cmd_in;
         phase_ff      <= phase_in;
         pen_x_ff      <= pen_x_in;
         pen_y_ff      <= pen_y_in;
         pend_x_ff     <= pend_x_in;
         vis_col_ff    <= vis_col_in;
         vis_en_ff     <= vis_en_in;
         pri_col_ff    <= pri_col_in;
         pri_en_ff     <= pri_en_in;
         brush_code_ff <= brush_code_in;
         brush_num_ff  <= brush_num_in;
         finished_ff   <= finished_in;
      end
   end

endmodule

>>> src/vector_picture_command_decoder.sv
// ----------------------------------------------------------------------------
// vector_picture_command_decoder
// Turns a vector picture byte stream into draw command words.
// ----------------------------------------------------------------------------
// One picture byte is taken per cycle while req_tready is high and is decoded
// against the command state in the same cycle; a byte that completes a command
// gives one word, registered into the output word register, or into the
// one-word skid register that backs it when the output is stalled. req_tready, a
// flop, drops only when both hold a word that the consumer has not yet taken;
// with rsp_tready high the rate is one byte per clock. Bytes after the
// end-of-picture word are taken and dropped until reset.
module vector_picture_command_decoder #(
   parameter int PIC_WIDTH  = 160,
   parameter int PIC_HEIGHT = 168
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [7:0]                    req_tdata,  // [7:0] pic_byte
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // [7:0] from_x, [15:8] from_y, [23:16] to_x, [31:24] to_y, [32] visual_on,
   // [40:33] visual_colour, [41] priority_on, [49:42] priority_colour,
   // [57:50] brush_code, [64:58] brush_number, [71:65] zero
   output logic [vpcd_pkg::TDATA_W-1:0]  rsp_tdata,
   output logic [vpcd_pkg::TUSER_W-1:0]  rsp_tuser   // [2:0] cmd_kind
);

   logic                 take;
   logic                 res_valid;
   vpcd_pkg::result_type res;
   vpcd_pkg::result_type out_ff, skid_ff;
   logic                 out_v_ff, skid_v_ff;
   logic                 out_take;

   assign req_tready = ~skid_v_ff;
   assign take       = req_tvalid & req_tready;
   assign out_take   = out_v_ff & rsp_tready;

   vpcd_core #(
      .PIC_WIDTH  (PIC_WIDTH),
      .PIC_HEIGHT (PIC_HEIGHT)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .byte_take (take),
      .pic_byte  (req_tdata),
      .res_valid (res_valid),
      .res       (res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else if (skid_v_ff) begin
         if (out_take) begin
            out_v_ff  <= 1'b1;
            skid_v_ff <= 1'b0;
         end
      end else if (res_valid) begin
         if (out_v_ff && !rsp_tready) begin
            skid_v_ff <= 1'b1;
         end else begin
            out_v_ff <= 1'b1;
         end
      end else if (out_take) begin
         out_v_ff <= 1'b0;
      end
   end

   // payload: advance skid into output, or load the fresh word into output or skid
   always_ff @(posedge clock) begin
      if (skid_v_ff) begin
         if (out_take) begin
            out_ff <= skid_ff;
         end
      end else if (res_valid) begin
         if (out_v_ff && !rsp_tready) begin
            skid_ff <= res;
         end else begin
            out_ff <= res;
         end
      end
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tuser  = out_ff.cmd_kind;
   assign rsp_tdata  = {7'd0, out_ff.brush_number, out_ff.brush_code,
                        out_ff.priority_colour, out_ff.priority_on,
                        out_ff.visual_colour, out_ff.visual_on,
                        out_ff.to_y, out_ff.to_x, out_ff.from_y, out_ff.from_x};

endmodule

>>> src/vpcd_checker.sv
// ----------------------------------------------------------------------------
// vpcd_checker
// Port-level checks for the vector picture command decoder.
// ----------------------------------------------------------------------------
module vpcd_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         rsp_tvalid,
   input logic                         rsp_tready,
   input logic [vpcd_pkg::TDATA_W-1:0] rsp_tdata,
   input logic [vpcd_pkg::TUSER_W-1:0] rsp_tuser
);

   // a stalled word holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled rsp word changed");

   assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_tvalid)
      else $error("rsp word valid straight after reset");

   // only line words carry a start point
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != vpcd_pkg::KIND_LINE |-> rsp_tdata[15:0] == 16'd0)
      else $error("start point set on a non-line word");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == vpcd_pkg::KIND_END |-> rsp_tdata[31:0] == 32'd0)
      else $error("end word carries coordinates");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tuser <= vpcd_pkg::KIND_END && rsp_tdata[71:65] == 7'd0)
      else $error("bad kind or padding on rsp word");

endmodule

bind vector_picture_command_decoder vpcd_checker u_vpcd_checker (.*);
